### hw/rtl/nmea_gsv_snr_parser_unit_assert.svh
// Assertion macros used by the parser RTL controller.
// No dependencies; included by nmea_gsv_ctrl, which carries concurrent checks.
`ifndef NMEA_GSV_SNR_PARSER_UNIT_ASSERT_SVH
`define NMEA_GSV_SNR_PARSER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define NGSV_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");
`define NGSV_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");
`else
`define NGSV_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define NGSV_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

### hw/rtl/nmea_gsv_pkg.sv
// Shared types and constants for the GSV sentence SNR parser.
// No dependencies.
`default_nettype none

package nmea_gsv_pkg;

    localparam int MAX_CHARS_DEF = 127;
    localparam int BAR_SLOTS_DEF = 16;

    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_G      = 8'h47;
    localparam logic [7:0] CH_S      = 8'h53;
    localparam logic [7:0] CH_V      = 8'h56;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;

    localparam int FIELD_W  = 6;
    localparam int DV_W     = 8;
    localparam int CNT_W    = 6;
    localparam int SUM_W    = 13;
    localparam int SATS_W   = 9;
    localparam int AVG_W    = 12;
    localparam int IDX_W    = 4;
    localparam int STORED_W = 5;
    localparam int DIV_W    = SUM_W + 4;
    localparam int OUT_DATA_W = 64;

    localparam logic [FIELD_W-1:0] FIELD_TOP  = 6'd63;
    localparam logic [FIELD_W-1:0] SATS_FIELD = 6'd3;
    localparam logic [FIELD_W-1:0] SNR_FIRST  = 6'd7;
    localparam logic [DV_W-1:0]    DV_MAX     = 8'd255;
    localparam logic [AVG_W-1:0]   AVG_MAX    = 12'd4080;
    localparam int                 MIN_LAST_POS = 6;

    localparam logic KIND_BAR = 1'b0;
    localparam logic KIND_SUM = 1'b1;

    typedef struct packed {
        logic accept;
        logic div_start;
        logic load_bar;
        logic bar_last;
        logic load_sum;
    } dp_cmd_t;

    typedef struct packed {
        logic bar_hit;
        logic sum_hit;
        logic out_free;
        logic div_done;
    } dp_status_t;

    typedef struct packed {
        logic [3:0]          pad;
        logic [STORED_W-1:0] bars_stored;
        logic [DV_W-1:0]     snr_peak_ever;
        logic [DV_W-1:0]     snr_peak;
        logic [AVG_W-1:0]    snr_average;
        logic [CNT_W-1:0]    snr_count;
        logic [SATS_W-1:0]   sats_in_view;
        logic [DV_W-1:0]     bar_value;
        logic [IDX_W-1:0]    bar_index;
    } out_payload_t;

endpackage

`default_nettype wire

### hw/rtl/nmea_gsv_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on nothing; used by the parser datapath for the SNR average.
`default_nettype none

module nmea_gsv_div #(
    parameter int DIVIDEND_W = 17,
    parameter int DIVISOR_W  = 6
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    input  wire logic [DIVIDEND_W-1:0] dividend,
    input  wire logic [DIVISOR_W-1:0]  divisor,
    output logic                       done,
    output logic [DIVIDEND_W-1:0]      quotient
);

    localparam int STEP_W = $clog2(DIVIDEND_W + 1);

    logic [STEP_W-1:0]     step_reg;
    logic [DIVISOR_W-1:0]  rem_reg;
    logic [DIVISOR_W-1:0]  dvsr_reg;
    logic [DIVIDEND_W-1:0] quo_reg;
    logic [DIVISOR_W:0]    shifted;
    logic [DIVISOR_W:0]    diff;
    logic                  ge;

    assign shifted  = {rem_reg, quo_reg[DIVIDEND_W-1]};
    assign ge       = shifted >= {1'b0, dvsr_reg};
    assign diff     = shifted - {1'b0, dvsr_reg};
    assign done     = step_reg == '0;
    assign quotient = quo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
        end
        else if (start)
        begin
            step_reg <= STEP_W'(DIVIDEND_W);
        end
        else if (!done)
        begin
            step_reg <= step_reg - STEP_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg  <= '0;
            dvsr_reg <= divisor;
            quo_reg  <= dividend;
        end
        else if (!done)
        begin
            rem_reg <= ge ? diff[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
            quo_reg <= {quo_reg[DIVIDEND_W-2:0], ge};
        end
    end

endmodule

`default_nettype wire

### hw/rtl/nmea_gsv_dp.sv
// Datapath: sentence parse state, SNR accumulation, average divider, result register.
// Depends on nmea_gsv_pkg and nmea_gsv_div.
`default_nettype none

module nmea_gsv_dp #(
    parameter int MAX_CHARS = nmea_gsv_pkg::MAX_CHARS_DEF,
    parameter int BAR_SLOTS = nmea_gsv_pkg::BAR_SLOTS_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire nmea_gsv_pkg::dp_cmd_t               cmd,
    output nmea_gsv_pkg::dp_status_t                 status,
    input  wire logic [7:0]                          char_in,
    input  wire logic                                eos,
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    output logic [nmea_gsv_pkg::OUT_DATA_W-1:0]      m_tdata,
    output logic                                     m_tuser,
    output logic                                     m_tlast
);

    localparam int POS_W   = $clog2(MAX_CHARS + 1);
    localparam int TALLY_W = $clog2(BAR_SLOTS + 1);

    typedef struct packed {
        logic [nmea_gsv_pkg::CNT_W-1:0]  cnt;
        logic [nmea_gsv_pkg::SUM_W-1:0]  sum;
        logic [nmea_gsv_pkg::DV_W-1:0]   peak;
        logic [TALLY_W-1:0]              tally;
        logic [nmea_gsv_pkg::SATS_W-1:0] sats;
        logic                            bar_hit;
        logic [nmea_gsv_pkg::DV_W-1:0]   bar_val;
        logic [TALLY_W-1:0]              bar_idx;
    } acc_t;

    function automatic acc_t close_field(
        input logic                               hdr,
        input logic [nmea_gsv_pkg::FIELD_W-1:0]   fn,
        input logic [nmea_gsv_pkg::DV_W-1:0]      dv,
        input acc_t                               a
    );
        acc_t r;
        r = a;
        if (hdr)
        begin
            if (fn == nmea_gsv_pkg::SATS_FIELD)
            begin
                r.sats = {1'b0, dv};
            end
            if (fn >= nmea_gsv_pkg::SNR_FIRST && fn[1:0] == 2'd3 && dv != '0)
            begin
                r.cnt = a.cnt + nmea_gsv_pkg::CNT_W'(1);
                r.sum = a.sum + nmea_gsv_pkg::SUM_W'(dv);
                if (dv > a.peak)
                begin
                    r.peak = dv;
                end
                if (32'(a.tally) < BAR_SLOTS)
                begin
                    r.bar_hit = 1'b1;
                    r.bar_val = dv;
                    r.bar_idx = a.tally;
                    r.tally   = a.tally + TALLY_W'(1);
                end
            end
        end
        return r;
    endfunction

    logic [POS_W-1:0]                   pos_reg;
    logic                               hdr_reg;
    logic                               star_reg;
    logic [nmea_gsv_pkg::FIELD_W-1:0]   fn_reg;
    logic [nmea_gsv_pkg::DV_W-1:0]      dv_reg;
    logic                               done_reg;
    logic [nmea_gsv_pkg::CNT_W-1:0]     cnt_reg;
    logic [nmea_gsv_pkg::SUM_W-1:0]     sum_reg;
    logic [nmea_gsv_pkg::DV_W-1:0]      peak_reg;
    logic [TALLY_W-1:0]                 tally_reg;
    logic [nmea_gsv_pkg::SATS_W-1:0]    sats_reg;
    logic [nmea_gsv_pkg::DV_W-1:0]      pe_reg;

    logic [POS_W-1:0]                   pos_next;
    logic                               hdr_next;
    logic                               star_next;
    logic [nmea_gsv_pkg::FIELD_W-1:0]   fn_next;
    logic [nmea_gsv_pkg::DV_W-1:0]      dv_next;
    logic                               done_next;
    logic [nmea_gsv_pkg::DV_W-1:0]      pe_next;
    logic [11:0]                        dv_prod;
    logic                               is_digit;
    logic                               active;
    logic                               sum_hit;
    acc_t                               acc0;
    acc_t                               acc1;
    acc_t                               acc2;

    logic [nmea_gsv_pkg::DV_W-1:0]      bar_val_reg;
    logic [nmea_gsv_pkg::IDX_W-1:0]     bar_idx_reg;
    logic [nmea_gsv_pkg::SATS_W-1:0]    sm_sats_reg;
    logic [nmea_gsv_pkg::CNT_W-1:0]     sm_cnt_reg;
    logic [nmea_gsv_pkg::DV_W-1:0]      sm_peak_reg;
    logic [nmea_gsv_pkg::STORED_W-1:0]  sm_stored_reg;

    logic                               div_done;
    logic [nmea_gsv_pkg::DIV_W-1:0]     quotient;
    logic [nmea_gsv_pkg::AVG_W-1:0]     avg;

    logic                               out_valid_reg;
    logic                               out_kind_reg;
    logic                               out_last_reg;
    nmea_gsv_pkg::out_payload_t         out_data_reg;
    nmea_gsv_pkg::out_payload_t         bar_payload;
    nmea_gsv_pkg::out_payload_t         sum_payload;

    always_comb
    begin
        pos_next  = (pos_reg < POS_W'(MAX_CHARS)) ? pos_reg + POS_W'(1) : pos_reg;
        hdr_next  = hdr_reg
                    & !(pos_reg == POS_W'(0) && char_in != nmea_gsv_pkg::CH_DOLLAR)
                    & !(pos_reg == POS_W'(3) && char_in != nmea_gsv_pkg::CH_G)
                    & !(pos_reg == POS_W'(4) && char_in != nmea_gsv_pkg::CH_S)
                    & !(pos_reg == POS_W'(5) && char_in != nmea_gsv_pkg::CH_V);
        active    = !star_reg && (pos_reg < POS_W'(MAX_CHARS));
        is_digit  = char_in >= nmea_gsv_pkg::CH_ZERO && char_in <= nmea_gsv_pkg::CH_NINE;
        dv_prod   = 12'(dv_reg) * 12'd10 + 12'(char_in - nmea_gsv_pkg::CH_ZERO);

        acc0 = '{cnt: cnt_reg, sum: sum_reg, peak: peak_reg, tally: tally_reg,
                 sats: sats_reg, bar_hit: 1'b0, bar_val: '0, bar_idx: '0};
        acc1      = acc0;
        dv_next   = dv_reg;
        done_next = done_reg;
        fn_next   = fn_reg;
        star_next = star_reg;

        if (active)
        begin
            if (char_in == nmea_gsv_pkg::CH_STAR)
            begin
                acc1      = close_field(hdr_next, fn_reg, dv_reg, acc0);
                dv_next   = '0;
                done_next = 1'b0;
                star_next = 1'b1;
            end
            else if (char_in == nmea_gsv_pkg::CH_COMMA)
            begin
                acc1      = close_field(hdr_next, fn_reg, dv_reg, acc0);
                dv_next   = '0;
                done_next = 1'b0;
                if (fn_reg == nmea_gsv_pkg::FIELD_TOP)
                begin
                    star_next = 1'b1;
                end
                else
                begin
                    fn_next = fn_reg + nmea_gsv_pkg::FIELD_W'(1);
                end
            end
            else if (is_digit && !done_reg)
            begin
                dv_next = (dv_prod > 12'(nmea_gsv_pkg::DV_MAX)) ? nmea_gsv_pkg::DV_MAX
                                                                : dv_prod[7:0];
            end
            else
            begin
                done_next = 1'b1;
            end
        end

        acc2 = acc1;
        if (eos && !star_next)
        begin
            acc2 = close_field(hdr_next, fn_next, dv_next, acc1);
        end

        sum_hit = eos && hdr_next && (pos_reg >= POS_W'(nmea_gsv_pkg::MIN_LAST_POS));
        pe_next = (sum_hit && acc2.cnt != '0 && acc2.peak > pe_reg) ? acc2.peak : pe_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            hdr_reg   <= 1'b1;
            star_reg  <= 1'b0;
            fn_reg    <= '0;
            dv_reg    <= '0;
            done_reg  <= 1'b0;
            cnt_reg   <= '0;
            sum_reg   <= '0;
            peak_reg  <= '0;
            tally_reg <= '0;
            sats_reg  <= '1;
            pe_reg    <= '0;
        end
        else if (cmd.accept)
        begin
            sats_reg <= acc2.sats;
            pe_reg   <= pe_next;
            if (eos)
            begin
                pos_reg   <= '0;
                hdr_reg   <= 1'b1;
                star_reg  <= 1'b0;
                fn_reg    <= '0;
                dv_reg    <= '0;
                done_reg  <= 1'b0;
                cnt_reg   <= '0;
                sum_reg   <= '0;
                peak_reg  <= '0;
                tally_reg <= '0;
            end
            else
            begin
                pos_reg   <= pos_next;
                hdr_reg   <= hdr_next;
                star_reg  <= star_next;
                fn_reg    <= fn_next;
                dv_reg    <= dv_next;
                done_reg  <= done_next;
                cnt_reg   <= acc2.cnt;
                sum_reg   <= acc2.sum;
                peak_reg  <= acc2.peak;
                tally_reg <= acc2.tally;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            bar_val_reg   <= acc2.bar_val;
            bar_idx_reg   <= nmea_gsv_pkg::IDX_W'(acc2.bar_idx);
            sm_sats_reg   <= acc2.sats;
            sm_cnt_reg    <= acc2.cnt;
            sm_peak_reg   <= acc2.peak;
            sm_stored_reg <= nmea_gsv_pkg::STORED_W'(acc2.tally);
        end
    end

    nmea_gsv_div #(
        .DIVIDEND_W (nmea_gsv_pkg::DIV_W),
        .DIVISOR_W  (nmea_gsv_pkg::CNT_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend ({acc2.sum, 4'b0000}),
        .divisor  (acc2.cnt),
        .done     (div_done),
        .quotient (quotient)
    );

    always_comb
    begin
        if (sm_cnt_reg == '0)
        begin
            avg = '0;
        end
        else if (quotient > nmea_gsv_pkg::DIV_W'(nmea_gsv_pkg::AVG_MAX))
        begin
            avg = nmea_gsv_pkg::AVG_MAX;
        end
        else
        begin
            avg = quotient[nmea_gsv_pkg::AVG_W-1:0];
        end

        bar_payload           = '0;
        bar_payload.bar_index = bar_idx_reg;
        bar_payload.bar_value = bar_val_reg;

        sum_payload               = '0;
        sum_payload.sats_in_view  = sm_sats_reg;
        sum_payload.snr_count     = sm_cnt_reg;
        sum_payload.snr_average   = avg;
        sum_payload.snr_peak      = sm_peak_reg;
        sum_payload.snr_peak_ever = pe_reg;
        sum_payload.bars_stored   = sm_stored_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_bar || cmd.load_sum)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_bar)
        begin
            out_data_reg <= bar_payload;
            out_kind_reg <= nmea_gsv_pkg::KIND_BAR;
            out_last_reg <= cmd.bar_last;
        end
        else if (cmd.load_sum)
        begin
            out_data_reg <= sum_payload;
            out_kind_reg <= nmea_gsv_pkg::KIND_SUM;
            out_last_reg <= 1'b1;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;

    assign status.bar_hit  = acc2.bar_hit;
    assign status.sum_hit  = sum_hit;
    assign status.out_free = !out_valid_reg || m_tready;
    assign status.div_done = div_done;

endmodule

`default_nettype wire

### hw/rtl/nmea_gsv_ctrl.sv
// Controller: accepts one character, then sequences the bar and summary results.
// Depends on nmea_gsv_pkg and nmea_gsv_snr_parser_unit_assert.svh.
`default_nettype none
`include "nmea_gsv_snr_parser_unit_assert.svh"

module nmea_gsv_ctrl (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       s_tvalid,
    output logic                            s_tready,
    output nmea_gsv_pkg::dp_cmd_t           cmd,
    input  wire nmea_gsv_pkg::dp_status_t   status
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_BAR  = 3'b010,
        ST_SUM  = 3'b100
    } ctrl_state_t;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;
    logic        sum_pend_reg;
    logic        sum_pend_next;

    always_comb
    begin
        state_next    = state_reg;
        sum_pend_next = sum_pend_reg;
        s_tready      = 1'b0;
        cmd           = '0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.accept    = 1'b1;
                    cmd.div_start = status.sum_hit;
                    sum_pend_next = status.sum_hit;
                    if (status.bar_hit)
                    begin
                        state_next = ST_BAR;
                    end
                    else if (status.sum_hit)
                    begin
                        state_next = ST_SUM;
                    end
                end
            end
            ST_BAR:
            begin
                if (status.out_free)
                begin
                    cmd.load_bar = 1'b1;
                    cmd.bar_last = !sum_pend_reg;
                    state_next   = sum_pend_reg ? ST_SUM : ST_IDLE;
                end
            end
            ST_SUM:
            begin
                if (status.out_free && status.div_done)
                begin
                    cmd.load_sum = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            sum_pend_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            sum_pend_reg <= sum_pend_next;
        end
    end

    `NGSV_ASSERT_IMPL(a_load_needs_room, clk, rst_n, cmd.load_bar || cmd.load_sum, status.out_free)
    `NGSV_ASSERT_IMPL(a_sum_after_divide, clk, rst_n, cmd.load_sum, status.div_done)
    `NGSV_ASSERT_NEXT(a_divide_runs, clk, rst_n, cmd.accept && status.sum_hit, !status.div_done && state_reg != ST_IDLE)

endmodule

`default_nettype wire

### hw/rtl/nmea_gsv_snr_parser_unit.sv
// Top level of the GSV sentence SNR parser.
// Depends on nmea_gsv_pkg, nmea_gsv_ctrl and nmea_gsv_dp.
//
// Takes one sentence character per input transaction (s_tlast marks the sentence's last
// character) and emits an SNR bar transaction (m_tuser 0) for each of the first BAR_SLOTS
// positive SNR fields, plus a summary transaction (m_tuser 1) at the end of a valid GSV
// sentence; m_tlast marks the final result of a character. A sentence's last character that
// yields a summary waits for the 17-step restoring divider that forms the Q8.4 average.
// The result register lets the next character enter while a result waits.
`default_nettype none

module nmea_gsv_snr_parser_unit #(
    parameter int MAX_CHARS = nmea_gsv_pkg::MAX_CHARS_DEF,
    parameter int BAR_SLOTS = nmea_gsv_pkg::BAR_SLOTS_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    input  wire logic [7:0]                          s_tdata,  // char_in
    input  wire logic                                s_tlast,
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    // bar_index, bar_value, sats_in_view, snr_count, snr_average, snr_peak,
    // snr_peak_ever, bars_stored, zero fill
    output logic [nmea_gsv_pkg::OUT_DATA_W-1:0]      m_tdata,
    output logic                                     m_tuser,  // kind
    output logic                                     m_tlast
);

    nmea_gsv_pkg::dp_cmd_t    cmd;
    nmea_gsv_pkg::dp_status_t status;

    nmea_gsv_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .cmd      (cmd),
        .status   (status)
    );

    nmea_gsv_dp #(
        .MAX_CHARS (MAX_CHARS),
        .BAR_SLOTS (BAR_SLOTS)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .status   (status),
        .char_in  (s_tdata),
        .eos      (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire

### dv/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for nmea_gsv_snr_parser_unit: streams GSV-style sentences
// and checks SNR bar and sentence summary transactions against a built-in predictor.
// Depends on nmea_gsv_pkg and the parser RTL.

module tb;

    localparam int SNR_STEP    = 4;
    localparam int MIN_LEN     = 7;
    localparam int RAND_CHARS  = 1850;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int DRAIN_WAIT  = 40;

    typedef struct packed {
        logic                       kind;
        nmea_gsv_pkg::out_payload_t pl;
        logic                       last;
    } gsv_result_t;

    typedef struct {
        logic [7:0]  ch;
        logic        eos;
        int          ntyped;
        gsv_result_t r0;
        gsv_result_t r1;
    } dir_row_t;

    logic                                clk;
    logic                                rst_n;
    logic                                s_tvalid;
    logic                                s_tready;
    logic [7:0]                          s_tdata;   // char_in
    logic                                s_tlast;
    logic                                m_tvalid;
    logic                                m_tready;
    // bar_index, bar_value, sats_in_view, snr_count, snr_average, snr_peak,
    // snr_peak_ever, bars_stored, zero fill
    logic [nmea_gsv_pkg::OUT_DATA_W-1:0] m_tdata;
    logic                                m_tuser;   // kind
    logic                                m_tlast;

    nmea_gsv_snr_parser_unit uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    gsv_result_t snr_results_due[$];
    dir_row_t    dir_tab[$];
    logic [7:0]  line_q[$];
    int          fail_cnt;
    int          cycles;
    int          chars_sent;
    bit          no_gaps;

    // predictor state
    int  chr_pos;
    bit  hdr_ok;
    bit  in_tail;
    int  fld_no;
    int  fld_val;
    bit  fld_stop;
    int  pos_cnt;
    int  pos_sum;
    int  sent_peak;
    int  bars_out;
    int  peak_all;
    int  sats_view;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb: FAIL");
            $finish;
        end
    end

    function automatic gsv_result_t mk_bar(int idx, int val, logic last);
        gsv_result_t r;
        r = '0;
        r.kind = nmea_gsv_pkg::KIND_BAR;
        r.pl.bar_index = idx[nmea_gsv_pkg::IDX_W-1:0];
        r.pl.bar_value = val[nmea_gsv_pkg::DV_W-1:0];
        r.last = last;
        return r;
    endfunction

    function automatic gsv_result_t mk_sum(int sats, int cnt, int avg, int pk, int pke,
                                           int stored);
        gsv_result_t r;
        r = '0;
        r.kind = nmea_gsv_pkg::KIND_SUM;
        r.pl.sats_in_view = sats[nmea_gsv_pkg::SATS_W-1:0];
        r.pl.snr_count = cnt[nmea_gsv_pkg::CNT_W-1:0];
        r.pl.snr_average = avg[nmea_gsv_pkg::AVG_W-1:0];
        r.pl.snr_peak = pk[nmea_gsv_pkg::DV_W-1:0];
        r.pl.snr_peak_ever = pke[nmea_gsv_pkg::DV_W-1:0];
        r.pl.bars_stored = stored[nmea_gsv_pkg::STORED_W-1:0];
        r.last = 1'b1;
        return r;
    endfunction

    function automatic void clear_sentence_state();
        chr_pos = 0;
        hdr_ok = 1'b1;
        in_tail = 1'b0;
        fld_no = 0;
        fld_val = 0;
        fld_stop = 1'b0;
        pos_cnt = 0;
        pos_sum = 0;
        sent_peak = 0;
        bars_out = 0;
    endfunction

    function automatic void close_gsv_field(ref gsv_result_t res[$]);
        if (hdr_ok)
        begin
            if (fld_no == int'(nmea_gsv_pkg::SATS_FIELD))
                sats_view = fld_val;
            if (fld_no >= int'(nmea_gsv_pkg::SNR_FIRST) &&
                (fld_no - int'(nmea_gsv_pkg::SNR_FIRST)) % SNR_STEP == 0 && fld_val > 0)
            begin
                pos_cnt++;
                pos_sum += fld_val;
                if (fld_val > sent_peak)
                    sent_peak = fld_val;
                if (bars_out < nmea_gsv_pkg::BAR_SLOTS_DEF)
                begin
                    res.push_back(mk_bar(bars_out, fld_val, 1'b0));
                    bars_out++;
                end
            end
        end
        fld_val = 0;
        fld_stop = 1'b0;
    endfunction

    function automatic void gsv_parse_char(logic [7:0] c, logic eos, ref gsv_result_t res[$]);
        int pos;
        int v;
        int avg;
        pos = chr_pos;
        if (chr_pos < nmea_gsv_pkg::MAX_CHARS_DEF)
            chr_pos++;
        if ((pos == 0 && c != nmea_gsv_pkg::CH_DOLLAR) || (pos == 3 && c != nmea_gsv_pkg::CH_G) ||
            (pos == 4 && c != nmea_gsv_pkg::CH_S) || (pos == 5 && c != nmea_gsv_pkg::CH_V))
            hdr_ok = 1'b0;
        if (!in_tail && pos < nmea_gsv_pkg::MAX_CHARS_DEF)
        begin
            if (c == nmea_gsv_pkg::CH_STAR)
            begin
                close_gsv_field(res);
                in_tail = 1'b1;
            end
            else if (c == nmea_gsv_pkg::CH_COMMA)
            begin
                close_gsv_field(res);
                if (fld_no >= int'(nmea_gsv_pkg::FIELD_TOP))
                    in_tail = 1'b1;
                else
                    fld_no++;
            end
            else if (c >= nmea_gsv_pkg::CH_ZERO && c <= nmea_gsv_pkg::CH_NINE && !fld_stop)
            begin
                v = fld_val * 10 + (int'(c) - int'(nmea_gsv_pkg::CH_ZERO));
                fld_val = (v > int'(nmea_gsv_pkg::DV_MAX)) ? int'(nmea_gsv_pkg::DV_MAX)
                                                            : v;
            end
            else
                fld_stop = 1'b1;
        end
        if (eos)
        begin
            if (!in_tail)
                close_gsv_field(res);
            if (hdr_ok && pos + 1 >= MIN_LEN)
            begin
                avg = 0;
                if (pos_cnt > 0)
                begin
                    avg = (pos_sum * 16) / pos_cnt;
                    if (sent_peak > peak_all)
                        peak_all = sent_peak;
                end
                if (avg > int'(nmea_gsv_pkg::AVG_MAX))
                    avg = int'(nmea_gsv_pkg::AVG_MAX);
                res.push_back(mk_sum(sats_view, pos_cnt, avg, sent_peak, peak_all, bars_out));
            end
            clear_sentence_state();
        end
        if (res.size() > 0)
            res[res.size()-1].last = 1'b1;
    endfunction

    function automatic void check_field(string name, int e, int a);
        if (e != a)
        begin
            fail_cnt++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, e, a);
        end
    endfunction

    always @(posedge clk)
    begin
        gsv_result_t got;
        gsv_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.kind = m_tuser;
            got.pl = m_tdata;
            got.last = m_tlast;
            if (snr_results_due.size() == 0)
            begin
                fail_cnt++;
                $display("%0t: unexpected result, expected none, got kind %0d data %h",
                         $time, got.kind, m_tdata);
            end
            else
            begin
                want = snr_results_due.pop_front();
                check_field("kind", int'(want.kind), int'(got.kind));
                check_field("bar_index", int'(want.pl.bar_index), int'(got.pl.bar_index));
                check_field("bar_value", int'(want.pl.bar_value), int'(got.pl.bar_value));
                check_field("sats_in_view", int'(want.pl.sats_in_view),
                            int'(got.pl.sats_in_view));
                check_field("snr_count", int'(want.pl.snr_count), int'(got.pl.snr_count));
                check_field("snr_average", int'(want.pl.snr_average),
                            int'(got.pl.snr_average));
                check_field("snr_peak", int'(want.pl.snr_peak), int'(got.pl.snr_peak));
                check_field("snr_peak_ever", int'(want.pl.snr_peak_ever),
                            int'(got.pl.snr_peak_ever));
                check_field("bars_stored", int'(want.pl.bars_stored),
                            int'(got.pl.bars_stored));
                check_field("last", int'(want.last), int'(got.last));
            end
        end
    end

    // output back-pressure: short ready runs, short and long stalls, long ready stretches
    int rdy_left;
    int rdy_pick;
    always @(negedge clk)
    begin
        if (rdy_left > 0)
            rdy_left--;
        else
        begin
            rdy_pick = $urandom_range(0, 99);
            if (rdy_pick < 45)
            begin
                m_tready <= 1'b1;
                rdy_left = $urandom_range(0, 7);
            end
            else if (rdy_pick < 55)
            begin
                m_tready <= 1'b1;
                rdy_left = $urandom_range(50, 200);
            end
            else if (rdy_pick < 90)
            begin
                m_tready <= 1'b0;
                rdy_left = $urandom_range(0, 2);
            end
            else
            begin
                m_tready <= 1'b0;
                rdy_left = $urandom_range(8, 40);
            end
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    task automatic send_char(logic [7:0] c, logic eos, int ntyped, gsv_result_t r0,
                             gsv_result_t r1);
        int gap;
        gsv_result_t res[$];
        gap = pick_gap();
        if (gap > 0)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata <= c;
        s_tlast <= eos;
        do @(posedge clk); while (!s_tready);
        gsv_parse_char(c, eos, res);
        if (ntyped < 0)
            foreach (res[i]) snr_results_due.push_back(res[i]);
        else
        begin
            if (ntyped > 0)
                snr_results_due.push_back(r0);
            if (ntyped > 1)
                snr_results_due.push_back(r1);
        end
    endtask

    task automatic wait_results_done();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (snr_results_due.size() != 0)
            @(posedge clk);
    endtask

    task automatic add_row(logic [7:0] c, logic eos, int ntyped, gsv_result_t r0,
                           gsv_result_t r1);
        dir_row_t row;
        row.ch = c;
        row.eos = eos;
        row.ntyped = ntyped;
        row.r0 = r0;
        row.r1 = r1;
        dir_tab.push_back(row);
    endtask

    task automatic add_text(string s);
        foreach (s[i]) add_row(s[i], 1'b0, -1, '0, '0);
    endtask

    function automatic void put_str(string s);
        foreach (s[i]) line_q.push_back(s[i]);
    endfunction

    function automatic void put_num(int v);
        put_str($sformatf("%0d", v));
    endfunction

    function automatic void put_hex2();
        string hx;
        hx = "0123456789ABCDEF";
        line_q.push_back(hx[$urandom_range(0, 15)]);
        line_q.push_back(hx[$urandom_range(0, 15)]);
    endfunction

    function automatic void put_snr();
        int r;
        r = $urandom_range(0, 99);
        if (r < 15)
            return;
        else if (r < 25)
            put_str($urandom_range(0, 1) ? "0" : "00");
        else if (r < 70)
            put_str($sformatf("%02d", $urandom_range(1, 99)));
        else if (r < 82)
            put_num($urandom_range(100, 999));
        else if (r < 92)
        begin
            put_str($urandom_range(0, 1) ? " " : "-");
            put_num($urandom_range(1, 99));
        end
        else
        begin
            put_num($urandom_range(1, 99));
            line_q.push_back(8'(8'h41 + $urandom_range(0, 25)));
        end
    endfunction

    function automatic void build_gsv(int max_groups);
        int r;
        int groups;
        line_q.delete();
        line_q.push_back(nmea_gsv_pkg::CH_DOLLAR);
        line_q.push_back(8'(8'h41 + $urandom_range(0, 25)));
        line_q.push_back(8'(8'h41 + $urandom_range(0, 25)));
        put_str("GSV,");
        put_num($urandom_range(1, 3));
        put_str(",");
        put_num($urandom_range(1, 3));
        put_str(",");
        r = $urandom_range(0, 99);
        if (r >= 15 && r < 25)
            put_num($urandom_range(100, 999));
        else if (r >= 25)
            put_num($urandom_range(0, 20));
        groups = $urandom_range(0, max_groups);
        for (int g = 0; g < groups; g++)
        begin
            put_str(",");
            if ($urandom_range(0, 9) != 0)
                put_num($urandom_range(1, 99));
            put_str(",");
            put_num($urandom_range(0, 90));
            put_str(",");
            put_num($urandom_range(0, 359));
            put_str(",");
            put_snr();
        end
        r = $urandom_range(0, 99);
        if (r < 75)
        begin
            line_q.push_back(nmea_gsv_pkg::CH_STAR);
            put_hex2();
            if (r >= 60)
            begin
                line_q.push_back(8'h0D);
                line_q.push_back(8'h0A);
            end
        end
        else if (r < 85)
        begin
            line_q.push_back(nmea_gsv_pkg::CH_STAR);
            put_str(",12,*");
        end
    endfunction

    function automatic void build_dense();
        int n;
        int r;
        line_q.delete();
        put_str("$GPGSV");
        n = $urandom_range(8, 70);
        for (int f = 1; f <= n; f++)
        begin
            line_q.push_back(nmea_gsv_pkg::CH_COMMA);
            r = $urandom_range(0, 99);
            if (f >= int'(nmea_gsv_pkg::SNR_FIRST) &&
                (f - int'(nmea_gsv_pkg::SNR_FIRST)) % SNR_STEP == 0)
            begin
                if (r < 85)
                    put_num($urandom_range(1, 255));
                else if (r < 92)
                    put_str("0");
            end
            else if (r < 10)
                put_num($urandom_range(0, 9));
        end
        if ($urandom_range(0, 1))
        begin
            line_q.push_back(nmea_gsv_pkg::CH_STAR);
            put_hex2();
        end
    endfunction

    function automatic void build_noise();
        int n;
        line_q.delete();
        n = $urandom_range(1, 12);
        for (int i = 0; i < n; i++)
            line_q.push_back(8'($urandom_range(0, 255)));
        if ($urandom_range(0, 9) < 3)
            line_q[0] = nmea_gsv_pkg::CH_DOLLAR;
    endfunction

    function automatic void build_broken();
        int k;
        build_gsv(4);
        if ($urandom_range(0, 1))
            line_q[$urandom_range(0, line_q.size() - 1)] = 8'($urandom_range(0, 255));
        else
        begin
            k = $urandom_range(1, line_q.size());
            while (line_q.size() > k)
                void'(line_q.pop_back());
        end
    endfunction

    initial
    begin
        int r;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tlast = 1'b0;
        m_tready = 1'b0;
        fail_cnt = 0;
        cycles = 0;
        chars_sent = 0;
        no_gaps = 1'b0;
        rdy_left = 0;

        // empty satellites field, one SNR closed by the last character
        add_text("$GPGSV,,,,,,,");
        add_row("9", 1'b1, 2, mk_bar(0, 9, 1'b0), mk_sum(0, 1, 144, 9, 9, 1));
        // extreme characters, bad header, too short
        add_row(8'h00, 1'b0, -1, '0, '0);
        add_row(8'hFF, 1'b1, 0, '0, '0);
        // shortest valid sentence, data ended by a star
        add_text("$AAGSV");
        add_row(nmea_gsv_pkg::CH_STAR, 1'b1, 1, mk_sum(0, 0, 0, 0, 9, 0), '0);
        add_row(nmea_gsv_pkg::CH_DOLLAR, 1'b1, 0, '0, '0);

        clear_sentence_state();
        peak_all = 0;
        sats_view = -1;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (dir_tab[i])
            send_char(dir_tab[i].ch, dir_tab[i].eos, dir_tab[i].ntyped, dir_tab[i].r0,
                      dir_tab[i].r1);
        wait_results_done();

        while (chars_sent < RAND_CHARS)
        begin
            r = $urandom_range(0, 99);
            if (r < 55)
                build_gsv(4);
            else if (r < 62)
                build_gsv(10);
            else if (r < 72)
                build_dense();
            else if (r < 86)
                build_broken();
            else
                build_noise();
            no_gaps = ($urandom_range(0, 9) < 3);
            foreach (line_q[i])
                send_char(line_q[i], i == line_q.size() - 1, -1, '0, '0);
            chars_sent += line_q.size();
            if ($urandom_range(0, 19) == 0)
                wait_results_done();
        end

        @(negedge clk);
        s_tvalid <= 1'b0;
        wait_results_done();
        repeat (DRAIN_WAIT) @(posedge clk);
        if (fail_cnt == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule
